// File: rtl/core/tsp_pkg.sv
// tsp_pkg: shared types and codes for the TLV stream parser.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package tsp_pkg;

   localparam logic [7:0] TAG_EXT_MASK = 8'h1F;
   localparam logic [7:0] LEN_ONE_BYTE = 8'h81;
   localparam logic [7:0] LEN_TWO_BYTE = 8'h82;
   localparam logic [7:0] LEN_SHORT_MAX = 8'd127;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_TRUNCATED = 2'd1;
   localparam logic [1:0] ERR_BAD_LENGTH = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } tsp_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] item_tag;
      logic [15:0] item_length;
      logic [7:0]  value_byte;
      logic        item_end;
      logic [1:0]  error_code;
   } tsp_rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
      logic       tag_ext;
      logic       len_short;
      logic       len_one;
      logic       len_two;
   } tsp_entry_type;

   typedef enum logic [2:0] {
      PH_TAG1,
      PH_TAG2,
      PH_LEN,
      PH_LEN81,
      PH_LEN82H,
      PH_LEN82L,
      PH_VALUE,
      PH_SKIP
   } tsp_phase_type;

endpackage
`default_nettype wire

// File: rtl/core/tsp_front.sv
// tsp_front: accepts input bytes and classifies each one for the back end.
// Depends on tsp_pkg.
`default_nettype none
module tsp_front
   import tsp_pkg::*;
(
   input  wire logic          req_valid,
   input  wire tsp_req_type   req_data,
   input  wire logic          queue_full,
   output logic               req_stall,
   output logic               push,
   output tsp_entry_type      push_entry
);

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

   always_comb begin
      push_entry.data_byte = req_data.data_byte;
      push_entry.buffer_end = req_data.buffer_end;
      push_entry.tag_ext = (req_data.data_byte & TAG_EXT_MASK) == TAG_EXT_MASK;
      push_entry.len_short = req_data.data_byte <= LEN_SHORT_MAX;
      push_entry.len_one = req_data.data_byte == LEN_ONE_BYTE;
      push_entry.len_two = req_data.data_byte == LEN_TWO_BYTE;
   end

endmodule
`default_nettype wire

// File: rtl/core/tsp_queue.sv
// tsp_queue: short register queue between the front and back ends.
// Depends on tsp_pkg.
`default_nettype none
module tsp_queue
   import tsp_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire tsp_entry_type push_entry,
   input  wire logic          pop,
   output logic               full,
   output logic               not_empty,
   output tsp_entry_type      head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   tsp_entry_type slots_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full = count_ff == FULL_COUNT;
   assign not_empty = count_ff != '0;
   assign head = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: rtl/core/tsp_back.sv
// tsp_back: record state machine and result register of the TLV parser.
// Depends on tsp_pkg; fed by tsp_queue.
`default_nettype none
module tsp_back
   import tsp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          entry_valid,
   input  wire tsp_entry_type entry,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output tsp_rsp_type        rsp_data
);

   tsp_phase_type phase_ff, phase_in;
   logic [15:0]   tag_ff, tag_in;
   logic [15:0]   length_ff, length_in;
   logic [15:0]   left_ff, left_in;
   logic          rsp_valid_ff, rsp_valid_in;
   tsp_rsp_type   rsp_ff, rsp_in;

   logic          slot_free;
   logic          last;
   logic [7:0]    b;
   logic [15:0]   len_value;
   logic [15:0]   left_dec;
   logic          emit;
   tsp_rsp_type   result;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop = entry_valid && slot_free;
   assign last = entry.buffer_end;
   assign b = entry.data_byte;
   assign left_dec = left_ff - 16'd1;

   always_comb begin
      case (phase_ff)
         PH_LEN, PH_LEN81: len_value = {8'h00, b};
         PH_LEN82L: len_value = {length_ff[15:8], b};
         default: len_value = length_ff;
      endcase
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      tag_in = tag_ff;
      length_in = length_ff;
      left_in = left_ff;
      case (phase_ff)
         PH_TAG1: begin
            tag_in = {8'h00, b};
            phase_in = last ? PH_TAG1 : (entry.tag_ext ? PH_TAG2 : PH_LEN);
         end
         PH_TAG2: begin
            tag_in = {tag_ff[7:0], b};
            phase_in = last ? PH_TAG1 : PH_LEN;
         end
         PH_LEN, PH_LEN81, PH_LEN82L: begin
            if (phase_ff != PH_LEN || entry.len_short) begin
               length_in = len_value;
               left_in = len_value;
               phase_in = (len_value == '0 || last) ? PH_TAG1 : PH_VALUE;
            end else if (!entry.len_one && !entry.len_two) begin
               phase_in = last ? PH_TAG1 : PH_SKIP;
            end else if (last) begin
               phase_in = PH_TAG1;
            end else begin
               phase_in = entry.len_one ? PH_LEN81 : PH_LEN82H;
            end
         end
         PH_LEN82H: begin
            length_in = {b, 8'h00};
            phase_in = last ? PH_TAG1 : PH_LEN82L;
         end
         PH_VALUE: begin
            left_in = left_dec;
            phase_in = (left_dec == '0 || last) ? PH_TAG1 : PH_VALUE;
         end
         PH_SKIP: begin
            phase_in = last ? PH_TAG1 : PH_SKIP;
         end
         default: phase_in = PH_TAG1;
      endcase
   end

   // result
   always_comb begin
      emit = 1'b0;
      result = '0;
      case (phase_ff)
         PH_TAG1, PH_TAG2, PH_LEN82H: begin
            if (last) begin
               emit = 1'b1;
               result.kind = KIND_ERROR;
               result.error_code = ERR_TRUNCATED;
            end
         end
         PH_LEN, PH_LEN81, PH_LEN82L: begin
            emit = 1'b1;
            if (phase_ff != PH_LEN || entry.len_short) begin
               if (len_value != '0 && last) begin
                  result.kind = KIND_ERROR;
                  result.error_code = ERR_TRUNCATED;
               end else begin
                  result.kind = KIND_HEADER;
                  result.item_tag = tag_ff;
                  result.item_length = len_value;
                  result.item_end = len_value == '0;
               end
            end else if (!entry.len_one && !entry.len_two) begin
               result.kind = KIND_ERROR;
               result.error_code = ERR_BAD_LENGTH;
            end else if (last) begin
               result.kind = KIND_ERROR;
               result.error_code = ERR_TRUNCATED;
            end else begin
               emit = 1'b0;
            end
         end
         PH_VALUE: begin
            emit = 1'b1;
            if (left_dec != '0 && last) begin
               result.kind = KIND_ERROR;
               result.error_code = ERR_TRUNCATED;
            end else begin
               result.kind = KIND_VALUE;
               result.item_tag = tag_ff;
               result.item_length = length_ff;
               result.value_byte = b;
               result.item_end = left_dec == '0;
            end
         end
         default: emit = 1'b0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (pop) begin
         rsp_valid_in = emit;
         rsp_in = result;
      end else if (slot_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TAG1;
         tag_ff <= '0;
         length_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff <= phase_in;
            tag_ff <= tag_in;
            length_ff <= length_in;
            left_ff <= left_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: rtl/core/tlv_stream_parser.sv
// tlv_stream_parser: top level of the BER-style TLV stream parser.
// Depends on tsp_pkg, tsp_front, tsp_queue and tsp_back.
//
//   channel  | ports                        | direction
//   ---------+------------------------------+----------
//   request  | req_valid, req_stall, req_data | in: one buffer byte per transfer
//   response | rsp_valid, rsp_stall, rsp_data | out: header, value byte or error
//
// One byte per cycle sustained while rsp_stall stays low; the record state machine
// in the back end handles one queued byte each cycle unless the response stalls.
// Each byte is held in the queue before its result, if any, enters the response register.
// Reset empties the queue, drops any pending result and returns to tag parsing.
// The request side stalls only while the queue is full; a response stall
// holds the result register and lets the queue fill behind it.
`default_nettype none
module tlv_stream_parser
   import tsp_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire tsp_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output tsp_rsp_type      rsp_data
);

   logic          queue_full;
   logic          push;
   tsp_entry_type push_entry;
   logic          pop;
   logic          queue_not_empty;
   tsp_entry_type head;

   tsp_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   tsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   tsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_not_empty),
      .entry       (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ERROR |->
         rsp_data.item_tag == '0 && rsp_data.item_length == '0 &&
         !rsp_data.item_end && rsp_data.error_code != ERR_NONE)
   else $error("error result carries item fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_HEADER |->
         rsp_data.item_end == (rsp_data.item_length == '0))
   else $error("header end flag disagrees with length");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> queue_not_empty && !(rsp_valid && rsp_stall))
   else $error("back end took a byte without room");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
   else $error("reset left a transfer pending");

endmodule
`default_nettype wire
